// ===== rtl/core/swm_pkg.sv =====
// Package for the sliding window median filter.
// Holds default sizes, cell operation codes and the cell control and link types.
// No dependencies.
package swm_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 32;

  // Window size register
  localparam int             CFG_W     = 5;
  localparam logic [CFG_W-1:0] WIN_RESET = 5'd3;

  // Cell operations, broadcast to every cell of the chain
  localparam logic [1:0] OP_HOLD     = 2'd0;
  localparam logic [1:0] OP_AGE      = 2'd1;
  localparam logic [1:0] OP_COLLAPSE = 2'd2;
  localparam logic [1:0] OP_INSERT   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       clear;  // with OP_AGE: drop the whole window
  } cell_ctrl_t;

  // Flags one cell hands to the next cell up the chain
  typedef struct packed {
    logic gt;    // valid and above the new sample
    logic open;  // valid and not above the new sample
    logic hole;  // an empty slot at or below this cell
  } cell_link_t;

endpackage

// ===== rtl/core/swm_if.sv =====
// Handshake interfaces for the sliding window median filter.
// Sample input, result output and window size write channels.
// Depends on swm_pkg.
interface swm_in_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_x2;

  modport source (output valid, output median_x2, input ready);
  modport sink   (input valid, input median_x2, output ready);
endinterface

interface swm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [swm_pkg::CFG_W-1:0]   window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

// ===== rtl/core/swm_cell.sv =====
// One cell of the sorted window chain: holds a sample, its age and a valid bit.
// Ages and drops its entry, closes holes and makes room for a new sample.
// Depends on swm_pkg.
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swm_pkg::cell_ctrl_t           ctrl,
  input  logic [CNT_W-1:0]              win,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // lower neighbor
  input  swm_pkg::cell_link_t           left_link,
  input  logic signed [SAMPLE_BITS-1:0] left_value,
  input  logic [CNT_W-1:0]              left_age,
  // upper neighbor
  input  logic                          right_valid,
  input  logic signed [SAMPLE_BITS-1:0] right_value,
  input  logic [CNT_W-1:0]              right_age,
  // own state
  output swm_pkg::cell_link_t           link,
  output logic                          valid,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [CNT_W-1:0]              age
);
  import swm_pkg::*;

  logic                          valid_r, valid_nxt;
  logic signed [SAMPLE_BITS-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]              age_r, age_nxt;
  logic [CNT_W:0]                age_inc;
  logic                          gt;

  assign gt        = valid_r && (value_r > sample);
  assign link.gt   = gt;
  assign link.open = valid_r && !gt;
  assign link.hole = left_link.hole || !valid_r;
  assign age_inc   = {1'b0, age_r} + 1'b1;

  // Next entry for the broadcast operation
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    age_nxt   = age_r;
    case (ctrl.op)
      OP_AGE: begin
        if (ctrl.clear) begin
          valid_nxt = 1'b0;
        end else begin
          valid_nxt = valid_r && (age_inc < {1'b0, win});
          age_nxt   = age_inc[CNT_W-1:0];
        end
      end
      OP_COLLAPSE: begin
        // everything above the lowest hole moves down one place
        if (link.hole) begin
          valid_nxt = right_valid;
          value_nxt = right_value;
          age_nxt   = right_age;
        end
      end
      OP_INSERT: begin
        if (left_link.gt) begin
          valid_nxt = 1'b1;
          value_nxt = left_value;
          age_nxt   = left_age;
        end else if (left_link.open && !link.open) begin
          valid_nxt = 1'b1;
          value_nxt = sample;
          age_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry registers, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
    age_r   <= age_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;
  assign age   = age_r;

endmodule

// ===== rtl/core/sliding_window_median.sv =====
// Sliding window median filter, top level: control sequencer, window size
// register, chain of sorting cells and median output register.
// Depends on swm_pkg, swm_if and swm_cell.
//
//  channel | direction | payload              | transfer when
//  in_ch   | sink      | sample, start_req    | in_ch.valid && in_ch.ready
//  out_ch  | source    | median_x2            | out_ch.valid && out_ch.ready
//  cfg_ch  | sink      | window_size          | cfg_ch.valid (ready tied high)
//
// Each sample runs through accept and age, then compaction steps, one per hole
// (one when the oldest sample is below the top entry, none when it is the top
// entry or nothing drops, more after a shrink), then one insert and one emit.
// A waiting result does not block the next accept; the emit cycle waits for
// the output register to free up. Synchronous active-low reset empties the
// window and sets the window size to 3.
module sliding_window_median #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  swm_in_if.sink    in_ch,
  swm_out_if.source out_ch,
  swm_cfg_if.sink   cfg_ch
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [CFG_W-1:0]              win_cfg_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS:0]   out_data_r;

  logic [CNT_W-1:0]              w_eff, lo_idx, hi_idx;
  cell_ctrl_t                    ctrl;
  logic                          in_fire, out_fire, any_bubble, full, emit_go;
  logic signed [SAMPLE_BITS-1:0] med_lo, med_hi;

  logic [MAX_WINDOW-1:0]         valid_vec;
  logic signed [SAMPLE_BITS-1:0] value_a [MAX_WINDOW];
  logic [CNT_W-1:0]              age_a   [MAX_WINDOW];
  cell_link_t                    link_a  [MAX_WINDOW];

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.median_x2 = out_data_r;

  // Window size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= WIN_RESET;
    end else if (cfg_ch.valid) begin
      win_cfg_r <= cfg_ch.window_size;
    end
  end

  // Effective window: zero means one, saturate at the chain length
  always_comb begin
    if (win_cfg_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(win_cfg_r) > MAX_WINDOW) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(win_cfg_r);
    end
  end

  assign lo_idx = (w_eff - 1'b1) >> 1;
  assign hi_idx = w_eff >> 1;

  // Sample held for the insert
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_ch.sample;
    end
  end

  // Hole below a valid entry means the chain still needs compacting
  always_comb begin
    any_bubble = 1'b0;
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      if (!valid_vec[i] && valid_vec[i+1]) begin
        any_bubble = 1'b1;
      end
    end
  end

  // Cell operation for this cycle
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.clear = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ctrl.op    = OP_AGE;
          ctrl.clear = in_ch.start_req;
        end
      end
      S_SORT: begin
        ctrl.op = any_bubble ? OP_COLLAPSE : OP_INSERT;
      end
      default: begin
      end
    endcase
  end

  // Cell chain
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    cell_link_t                    l_link;
    logic signed [SAMPLE_BITS-1:0] l_value, r_value;
    logic [CNT_W-1:0]              l_age, r_age;
    logic                          r_valid;

    if (g == 0) begin : g_bottom
      assign l_link  = '{gt: 1'b0, open: 1'b1, hole: 1'b0};
      assign l_value = '0;
      assign l_age   = '0;
    end else begin : g_mid
      assign l_link  = link_a[g-1];
      assign l_value = value_a[g-1];
      assign l_age   = age_a[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_top
      assign r_valid = 1'b0;
      assign r_value = '0;
      assign r_age   = '0;
    end else begin : g_below
      assign r_valid = valid_vec[g+1];
      assign r_value = value_a[g+1];
      assign r_age   = age_a[g+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .win         (w_eff),
      .sample      (sample_r),
      .left_link   (l_link),
      .left_value  (l_value),
      .left_age    (l_age),
      .right_valid (r_valid),
      .right_value (r_value),
      .right_age   (r_age),
      .link        (link_a[g]),
      .valid       (valid_vec[g]),
      .value       (value_a[g]),
      .age         (age_a[g])
    );
  end

  // Pick the middle entries and the fullness flag
  always_comb begin
    med_lo = '0;
    med_hi = '0;
    full   = 1'b0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (CNT_W'(i) == lo_idx) begin
        med_lo = value_a[i];
      end
      if (CNT_W'(i) == hi_idx) begin
        med_hi = value_a[i];
      end
      if (CNT_W'(i) == w_eff - 1'b1) begin
        full = valid_vec[i];
      end
    end
  end

  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SORT;
        end
      end
      S_SORT: begin
        if (!any_bubble) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_fire;
    if (emit_go) begin
      out_valid_nxt = full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register: sum of the two middle entries
  always_ff @(posedge clk) begin
    if (emit_go && full) begin
      out_data_r <= {med_lo[SAMPLE_BITS-1], med_lo} + {med_hi[SAMPLE_BITS-1], med_hi};
    end
  end

  // An accepted sample always goes to the sort phase next
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_SORT))
    else $error("accepted sample did not start the sort phase");

  // Once compacting ends, valid entries form an unbroken run from cell 0
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (((valid_vec >> 1) & ~valid_vec) == '0))
    else $error("window has a hole after insert");

  // In the emit step the chain holds no more entries than the window
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> ((valid_vec >> w_eff) == '0))
    else $error("window holds more samples than its size");

  // A new result only appears from the emit step
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire || !out_valid_r) ##1 out_valid_r |-> ($past(state_r) == S_EMIT))
    else $error("result appeared outside the emit step");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for sliding_window_median: random sample streams, a fixed plan of window sizes and
// handshake stalls, with every median checked against an internal sorted-window predictor.
// Depends on swm_pkg, the swm_if interfaces and the sliding_window_median RTL.
module tb;
  import swm_pkg::*;

  localparam int SB   = SAMPLE_BITS_DEF;
  localparam int MAXW = MAX_WINDOW_DEF;
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam int QUIET_CYCLES = 64;
  localparam int LONG_HOLD    = 300;

  // Sorted-window tracker: holds the window and the medians still owed by the block
  class median_tracker;
    logic [CFG_W-1:0]     window_reg;
    int                   fill;
    logic signed [SB-1:0] held [MAXW];
    int                   ages [MAXW];
    logic signed [SB:0]   medians_due [$];
    int                   errors;

    function new();
      window_reg = WIN_RESET;
      fill = 0;
      errors = 0;
    endfunction

    function void set_window(logic [CFG_W-1:0] v);
      window_reg = v;
    endfunction

    // zero acts as 1, anything above the chain length saturates
    function int span();
      if (window_reg == 0) return 1;
      if (window_reg > MAXW) return MAXW;
      return int'(window_reg);
    endfunction

    function void push_sample(logic signed [SB-1:0] s, logic start);
      int w, kept, pos, a, i;
      logic signed [SB:0] lo, hi;
      w = span();
      if (start) fill = 0;
      // age held samples, drop those that reached the window size
      kept = 0;
      for (i = 0; i < fill; i++) begin
        a = ages[i] + 1;
        if (a < w) begin
          held[kept] = held[i];
          ages[kept] = a;
          kept++;
        end
      end
      // insert after every held value not above the new one
      pos = kept;
      while (pos > 0 && held[pos-1] > s) begin
        held[pos] = held[pos-1];
        ages[pos] = ages[pos-1];
        pos--;
      end
      held[pos] = s;
      ages[pos] = 0;
      fill = kept + 1;
      if (fill == w) begin
        lo = {held[(w-1)/2][SB-1], held[(w-1)/2]};
        hi = {held[w/2][SB-1], held[w/2]};
        medians_due.push_back(lo + hi);
      end
    endfunction

    function void check_median(logic signed [SB:0] got);
      logic signed [SB:0] want;
      if (medians_due.size() == 0) begin
        $display("%0t: unexpected median, expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = medians_due.pop_front();
      if (got !== want) begin
        $display("%0t: median mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction

    function void check_leftover();
      if (medians_due.size() != 0) begin
        $display("%0t: %0d medians missing, expected %0d first, got none", $time,
                 medians_due.size(), medians_due[0]);
        errors += medians_due.size();
      end
    endfunction

    function bit busy();
      return medians_due.size() != 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_req;
  median_tracker medians;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();
  swm_cfg_if cfg_ch ();

  sliding_window_median u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // Transfer monitor: feeds the tracker and checks every median
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) medians.check_median(out_ch.median_x2);
    if (rst_n && in_ch.valid && in_ch.ready) medians.push_sample(in_ch.sample, in_ch.start_req);
  end

  // Result side stalls; one long hold-off on request so the block backs up
  initial begin
    int mode, seg, k;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 64);
      for (k = 0; k < seg; k++) begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (k % 5 != 2) && (k % 7 != 4);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return SB'($urandom_range(0, 8)) - SB'(4);  // many ties
      7: begin
        case ($urandom_range(0, 3))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return SB'($urandom_range(0, 2000)) - SB'(1000);
    endcase
  endfunction

  task automatic send_item(input logic signed [SB-1:0] s, input logic start);
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= s;
    in_ch.start_req <= start;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_input(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait for every owed median, then let any result-free item finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (medians.busy()) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    medians.set_window(v);
  endtask

  task automatic run_directed();
    // reset window of 3: extremes and ties
    send_item(S_MIN, 1'b1);
    send_item(S_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(S_MAX, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(S_MIN, 1'b0);
    // restart: nothing until the window refills
    send_item(SB'(5), 1'b1);
    send_item(SB'(5), 1'b0);
    send_item(SB'(5), 1'b0);
    drain();
    // window of 1, start still gives a result
    write_window(5'd1);
    send_item(S_MAX, 1'b1);
    send_item(S_MIN, 1'b0);
    drain();
    // zero behaves as a window of 1
    write_window(5'd0);
    send_item('1, 1'b0);
    send_item(SB'(7), 1'b1);
    drain();
    // even window
    write_window(5'd4);
    send_item(SB'(3), 1'b1);
    send_item(SB'(1), 1'b0);
    send_item(SB'(4), 1'b0);
    send_item(SB'(1), 1'b0);
    drain();
    // shrink mid-sequence: several old samples leave at once
    write_window(5'd2);
    send_item(SB'(9), 1'b0);
    drain();
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] win, input int count, input bit steady);
    int burst, k;
    logic first_start;
    write_window(win);
    first_start = ($urandom_range(0, 2) == 0);
    burst = $urandom_range(1, 40);
    for (k = 0; k < count; k++) begin
      if (!steady && burst == 0) begin
        idle_input(($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3));
        burst = $urandom_range(1, 40);
      end
      send_item(pick_sample(), (k == 0) ? first_start : ($urandom_range(0, 49) == 0));
      burst--;
    end
    drain();
  endtask

  // Main sequence
  initial begin
    logic [CFG_W-1:0] plan [12];
    int p;
    plan = '{5'd1, 5'd16, 5'd0, 5'd7, 5'd31, 5'd2, 5'd17, 5'd4, 5'd10, 5'd3, 5'd15, 5'd6};
    medians = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample       <= '0;
    in_ch.start_req    <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.window_size <= WIN_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (p = 0; p < 12; p++) begin
      // full-window phase with a long output stall while input keeps coming
      if (p == 1) hold_req = 1'b1;
      run_phase(plan[p], 150, (p == 1 || p == 6));
    end

    medians.check_leftover();
    if (medians.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
